>>> rtl/aesccm_pkg.sv
`default_nettype none
package aesccm_pkg;

  localparam int AES_ROUNDS = 10;
  localparam int RND_W = $clog2(AES_ROUNDS + 1);

  // input command codes
  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_ASSOC    = 3'd1;
  localparam logic [2:0] CMD_ENCRYPT  = 3'd2;
  localparam logic [2:0] CMD_DECRYPT  = 3'd3;
  localparam logic [2:0] CMD_FIN_ENC  = 3'd4;
  localparam logic [2:0] CMD_FIN_DEC  = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_bytes;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_START,
    OP_ASSOC,
    OP_ENC,
    OP_DEC,
    OP_FIN_ENC,
    OP_FIN_DEC
  } op_t;

  // classified item passed from front to back
  typedef struct packed {
    op_t          op;
    logic [127:0] data;
    logic [4:0]   cnt;
  } cmd_item_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [39:0] nonce_high;
    logic [63:0] nonce_low;
    logic [3:0]  nonce_bytes;
    logic [4:0]  tag_bytes;
    logic [63:0] assoc_length;
    logic [63:0] payload_length;
  } cfg_t;

  // forward s-box, byte 0 in the top bits
  localparam logic [2047:0] SBOX_TABLE = {
    256'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0,
    256'hb7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b275,
    256'h09832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf,
    256'hd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2,
    256'hcd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdb,
    256'he0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08,
    256'hba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9e,
    256'he1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_TABLE[(255 - int'(x)) * 8 +: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // mask of the first cnt bytes, cnt up to 16
  function automatic logic [127:0] byte_mask(input logic [4:0] cnt);
    return ~({128{1'b1}} >> {cnt, 3'b000});
  endfunction

  // one aes round: subbytes, shiftrows, mixcolumns unless last, add key
  function automatic logic [127:0] aes_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127 - 8 * i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i + 4 * c] = b[i + 4 * ((c + i) & 3)];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      if (last) begin
        o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        o[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        o[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        o[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    return o ^ rk;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] key_step(input logic [127:0] rk,
                                            input logic [7:0] rc);
    logic [31:0] tmp, n0, n1, n2, n3;
    tmp = {sbox(rk[23:16]), sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
    tmp = tmp ^ {rc, 24'h000000};
    n0 = rk[127:96] ^ tmp;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = rk[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage
`default_nettype wire

>>> rtl/aes_ccm_engine.sv
`default_nettype none
// AES-128 CCM engine.
// Input channel: an item (cmd, data_high, data_low, byte_count) is taken when
// push is high and full is low. A two-entry queue sits between the front,
// which classifies items and drops unknown codes and empty payload chunks,
// and the back, which runs them one at a time.
// Result channel: while empty is low the oldest result is on out_item; it is
// taken when pop is high. Only payload chunks and finish items give a result.
// Configuration: key, nonce, lengths and tag size are written through wr_en,
// wr_index and wr_data; start captures the key. The user must write them only
// while the engine is idle; the block itself does not enforce this.
// Each AES pass runs in a shared two-lane round unit, one round per cycle: a start
// runs one pass, an assoc chunk one when it fills a MAC block, a payload chunk a CTR
// pass with MAC flush, then its MAC pass, a finish a MAC flush pass if one is due.
// The back handles one item at a time; the front keeps taking items until
// the queue is full. If the receiver stalls, a finished result waits in the
// output register and the back holds before its next result.
// Reset clears configuration to its defaults, the CCM state, the input queue and the result register.
module aes_ccm_engine import aesccm_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  wire         pop,
  output out_item_t   out_item,
  input  wire         wr_en,
  input  wire  [2:0]  wr_index,
  input  wire  [63:0] wr_data
);

  localparam logic [2:0] REG_KEY_HIGH    = 3'd0;
  localparam logic [2:0] REG_KEY_LOW     = 3'd1;
  localparam logic [2:0] REG_NONCE_HIGH  = 3'd2;
  localparam logic [2:0] REG_NONCE_LOW   = 3'd3;
  localparam logic [2:0] REG_NONCE_BYTES = 3'd4;
  localparam logic [2:0] REG_TAG_BYTES   = 3'd5;
  localparam logic [2:0] REG_ASSOC_LEN   = 3'd6;
  localparam logic [2:0] REG_PAYLOAD_LEN = 3'd7;

  cfg_t      cfg;
  logic      q_valid;
  logic      q_pop;
  cmd_item_t q_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_high <= '0;
      cfg.key_low <= '0;
      cfg.nonce_high <= '0;
      cfg.nonce_low <= '0;
      cfg.nonce_bytes <= 4'd13;
      cfg.tag_bytes <= 5'd16;
      cfg.assoc_length <= '0;
      cfg.payload_length <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_KEY_HIGH:    cfg.key_high <= wr_data;
        REG_KEY_LOW:     cfg.key_low <= wr_data;
        REG_NONCE_HIGH:  cfg.nonce_high <= wr_data[39:0];
        REG_NONCE_LOW:   cfg.nonce_low <= wr_data;
        REG_NONCE_BYTES: cfg.nonce_bytes <= wr_data[3:0];
        REG_TAG_BYTES:   cfg.tag_bytes <= wr_data[4:0];
        REG_ASSOC_LEN:   cfg.assoc_length <= wr_data;
        REG_PAYLOAD_LEN: cfg.payload_length <= wr_data;
        default: ;
      endcase
    end
  end

  aesccm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (in_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  aesccm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // back only pops a queued item
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // an accepted start is queued in the next cycle
  a_start_queued: assert property (@(posedge clk) disable iff (rst)
    push && !full && in_item.cmd == CMD_START |=> q_valid)
    else $error("start item lost");

  // a full front always offers an item to the back
  a_full_offers: assert property (@(posedge clk) disable iff (rst) full |-> q_valid)
    else $error("full queue without item");

endmodule
`default_nettype wire

>>> rtl/aesccm_front.sv
`default_nettype none
module aesccm_front import aesccm_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  output logic       full,
  input  in_item_t   item,
  output logic       q_valid,
  input  wire        q_pop,
  output cmd_item_t  q_item
);

  cmd_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [4:0] cnt_sat;
  op_t        op;
  logic       keep;
  logic       wr;

  // classify the item, drop unknown codes and empty payload chunks
  always_comb begin
    cnt_sat = (item.byte_count > 5'd16) ? 5'd16 : item.byte_count;
    op = OP_START;
    keep = 1'b1;
    case (item.cmd)
      CMD_START:   op = OP_START;
      CMD_ASSOC:   op = OP_ASSOC;
      CMD_ENCRYPT: begin
        op = OP_ENC;
        keep = (cnt_sat != 5'd0);
      end
      CMD_DECRYPT: begin
        op = OP_DEC;
        keep = (cnt_sat != 5'd0);
      end
      CMD_FIN_ENC: op = OP_FIN_ENC;
      CMD_FIN_DEC: op = OP_FIN_DEC;
      default:     keep = 1'b0;
    endcase
  end

  assign full = (count == 2'd2);
  assign wr = push && !full && keep;
  assign q_valid = (count != 2'd0);
  assign q_item = slots[rd_ptr];

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, q_pop};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr].op <= op;
      slots[wr_ptr].data <= {item.data_high, item.data_low};
      slots[wr_ptr].cnt <= cnt_sat;
    end
  end

endmodule
`default_nettype wire

>>> rtl/aesccm_cipher.sv
`default_nettype none
module aesccm_cipher import aesccm_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  wire          start,
  input  wire  [127:0] key,
  input  wire  [127:0] in_a,
  input  wire  [127:0] in_b,
  output logic         done,
  output logic [127:0] out_a,
  output logic [127:0] out_b
);

  logic             busy;
  logic [RND_W-1:0] rnd;
  logic [127:0]     rk;
  logic [7:0]       rc;
  logic             last;

  assign last = (rnd == RND_W'(AES_ROUNDS));

  // two blocks side by side, one round per cycle, key schedule one round ahead
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        out_a <= in_a ^ key;
        out_b <= in_b ^ key;
        rk <= key_step(key, 8'h01);
        rc <= 8'h02;
        rnd <= RND_W'(1);
        busy <= 1'b1;
      end else if (busy) begin
        out_a <= aes_round(out_a, rk, last);
        out_b <= aes_round(out_b, rk, last);
        rk <= key_step(rk, rc);
        rc <= xt(rc);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          rnd <= rnd + RND_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/aesccm_back.sv
`default_nettype none
module aesccm_back import aesccm_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  cfg_t       cfg,
  input  wire        q_valid,
  output logic       q_pop,
  input  cmd_item_t  q_item,
  output logic       empty,
  input  wire        pop,
  output out_item_t  out_item
);

  localparam logic [1:0] STATUS_DATA     = 2'd0;
  localparam logic [1:0] STATUS_TAG_OK   = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;
  localparam logic [1:0] STATUS_INVALID  = 2'd3;
  localparam logic [63:0] HDR_SHORT_LIMIT = 64'd65280;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WAIT_START,
    ST_WAIT_MAC,
    ST_WAIT_CTR,
    ST_MAC2,
    ST_WAIT_PT,
    ST_EMIT,
    ST_WAIT_FLUSH,
    ST_FINISH
  } state_t;

  state_t       state;
  cmd_item_t    item;
  logic         res_valid;
  logic [127:0] kreg;
  logic [127:0] mac;
  logic [127:0] fks;
  logic [63:0]  ctr;
  logic [127:0] abuf;
  logic [3:0]   afill;
  logic [63:0]  aseen;
  logic [63:0]  pseen;
  logic         flushf;
  logic [127:0] res_r;
  logic [127:0] pt_r;

  logic         c_start;
  logic [127:0] c_in_a;
  logic         c_done;
  logic [127:0] c_out_a;
  logic [127:0] c_out_b;

  logic [3:0]   n_eff;
  logic [3:0]   q;
  logic [4:0]   t_sat;
  logic [4:0]   t_eff;
  logic [63:0]  mask64;
  logic [127:0] b0;
  logic [127:0] ctr0;
  logic [127:0] ctrb;
  logic [127:0] hdr;
  logic [3:0]   hdr_fill;
  logic [127:0] dmask;
  logic [255:0] comb_buf;
  logic [4:0]   tot;
  logic [127:0] res;
  logic [127:0] pt;
  logic [127:0] tag_mask;
  logic [127:0] tag_val;
  logic         len_ok;

  aesccm_cipher u_cipher (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .key   (kreg),
    .in_a  (c_in_a),
    .in_b  (ctrb),
    .done  (c_done),
    .out_a (c_out_a),
    .out_b (c_out_b)
  );

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign empty = !res_valid;

  // effective lengths
  always_comb begin
    if (cfg.nonce_bytes < 4'd7) n_eff = 4'd7;
    else if (cfg.nonce_bytes > 4'd13) n_eff = 4'd13;
    else n_eff = cfg.nonce_bytes;
    q = 4'd15 - n_eff;
    if (cfg.tag_bytes < 5'd4) t_sat = 5'd4;
    else if (cfg.tag_bytes > 5'd16) t_sat = 5'd16;
    else t_sat = cfg.tag_bytes;
    t_eff = {t_sat[4:1], 1'b0};
    mask64 = {64{1'b1}} >> (7'd64 - {q, 3'b000});
  end

  // b0, counter blocks and length header
  always_comb begin
    b0 = {1'b0, cfg.assoc_length != 64'd0, 3'(t_eff[4:1] - 4'd1), 3'(q - 4'd1),
          cfg.nonce_high, cfg.nonce_low, 16'h0000};
    b0[63:0] = (b0[63:0] & ~mask64) | (cfg.payload_length & mask64);
    ctr0 = {5'b00000, 3'(q - 4'd1), cfg.nonce_high, cfg.nonce_low, 16'h0000};
    ctr0[63:0] = ctr0[63:0] & ~mask64;
    ctrb = ctr0;
    ctrb[63:0] = ctr0[63:0] | (ctr & mask64);
    if (cfg.assoc_length == 64'd0) begin
      hdr = '0;
      hdr_fill = 4'd0;
    end else if (cfg.assoc_length < HDR_SHORT_LIMIT) begin
      hdr = {cfg.assoc_length[15:0], 112'b0};
      hdr_fill = 4'd2;
    end else if (cfg.assoc_length[63:32] == 32'd0) begin
      hdr = {16'hfffe, cfg.assoc_length[31:0], 80'b0};
      hdr_fill = 4'd6;
    end else begin
      hdr = {16'hffff, cfg.assoc_length, 48'b0};
      hdr_fill = 4'd10;
    end
  end

  // chunk realignment, ctr output and finish checks
  always_comb begin
    dmask = byte_mask(item.cnt);
    comb_buf = {abuf, 128'b0} | ({item.data & dmask, 128'b0} >> {afill, 3'b000});
    tot = {1'b0, afill} + item.cnt;
    res = (item.data ^ c_out_b) & dmask;
    pt = (item.op == OP_ENC) ? (item.data & dmask) : res;
    tag_mask = byte_mask(t_eff);
    tag_val = (mac ^ fks) & tag_mask;
    len_ok = 1'b1;
    if (cfg.nonce_bytes < 4'd7 || cfg.nonce_bytes > 4'd13) len_ok = 1'b0;
    if (cfg.tag_bytes < 5'd4 || cfg.tag_bytes > 5'd16 || cfg.tag_bytes[0]) len_ok = 1'b0;
    if ((cfg.payload_length & ~mask64) != 64'd0) len_ok = 1'b0;
    if (aseen != cfg.assoc_length || pseen != cfg.payload_length) len_ok = 1'b0;
    if (item.op == OP_FIN_DEC && cfg.payload_length == 64'd0) len_ok = 1'b0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
      c_start <= 1'b0;
      mac <= '0;
      fks <= '0;
      ctr <= '0;
      abuf <= '0;
      afill <= '0;
      aseen <= '0;
      pseen <= '0;
    end else begin
      c_start <= 1'b0;
      if (pop && res_valid) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          case (item.op)
            OP_START: begin
              kreg <= {cfg.key_high, cfg.key_low};
              c_start <= 1'b1;
              c_in_a <= b0;
              // counter zero on lane b gives the first keystream block
              ctr <= '0;
              state <= ST_WAIT_START;
            end
            OP_ASSOC: begin
              aseen <= aseen + 64'(item.cnt);
              afill <= tot[3:0];
              if (tot[4]) begin
                abuf <= comb_buf[127:0];
                c_start <= 1'b1;
                c_in_a <= mac ^ comb_buf[255:128];
                state <= ST_WAIT_MAC;
              end else begin
                abuf <= comb_buf[255:128];
                state <= ST_IDLE;
              end
            end
            OP_ENC, OP_DEC: begin
              flushf <= (afill != 4'd0);
              c_start <= 1'b1;
              c_in_a <= mac ^ abuf;
              state <= ST_WAIT_CTR;
            end
            OP_FIN_ENC, OP_FIN_DEC: begin
              if (afill != 4'd0) begin
                c_start <= 1'b1;
                c_in_a <= mac ^ abuf;
                state <= ST_WAIT_FLUSH;
              end else begin
                state <= ST_FINISH;
              end
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_WAIT_START: begin
          if (c_done) begin
            mac <= c_out_a;
            fks <= c_out_b;
            ctr <= 64'd1;
            abuf <= hdr;
            afill <= hdr_fill;
            aseen <= '0;
            pseen <= '0;
            state <= ST_IDLE;
          end
        end
        ST_WAIT_MAC: begin
          if (c_done) begin
            mac <= c_out_a;
            state <= ST_IDLE;
          end
        end
        ST_WAIT_CTR: begin
          if (c_done) begin
            if (flushf) mac <= c_out_a;
            abuf <= '0;
            afill <= '0;
            res_r <= res;
            pt_r <= pt;
            ctr <= ctr + 64'd1;
            pseen <= pseen + 64'(item.cnt);
            state <= ST_MAC2;
          end
        end
        ST_MAC2: begin
          c_start <= 1'b1;
          c_in_a <= mac ^ pt_r;
          state <= ST_WAIT_PT;
        end
        ST_WAIT_PT: begin
          if (c_done) begin
            mac <= c_out_a;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            out_item.result_high <= res_r[127:64];
            out_item.result_low <= res_r[63:0];
            out_item.result_bytes <= item.cnt;
            out_item.status <= STATUS_DATA;
            state <= ST_IDLE;
          end
        end
        ST_WAIT_FLUSH: begin
          if (c_done) begin
            mac <= c_out_a;
            abuf <= '0;
            afill <= '0;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            out_item.result_high <= '0;
            out_item.result_low <= '0;
            out_item.result_bytes <= '0;
            if (!len_ok) begin
              out_item.status <= STATUS_INVALID;
            end else if (item.op == OP_FIN_ENC) begin
              out_item.result_high <= tag_val[127:64];
              out_item.result_low <= tag_val[63:0];
              out_item.result_bytes <= t_eff;
              out_item.status <= STATUS_DATA;
            end else if (((item.data ^ fks) & tag_mask) == (mac & tag_mask)) begin
              out_item.status <= STATUS_TAG_OK;
            end else begin
              out_item.status <= STATUS_MISMATCH;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sim/ccm_tb_pkg.sv
`timescale 1ns / 100ps
package ccm_tb_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_HIGH    = 3'd0;
  localparam logic [2:0] REG_KEY_LOW     = 3'd1;
  localparam logic [2:0] REG_NONCE_HIGH  = 3'd2;
  localparam logic [2:0] REG_NONCE_LOW   = 3'd3;
  localparam logic [2:0] REG_NONCE_BYTES = 3'd4;
  localparam logic [2:0] REG_TAG_BYTES   = 3'd5;
  localparam logic [2:0] REG_ASSOC_LEN   = 3'd6;
  localparam logic [2:0] REG_PAYLOAD_LEN = 3'd7;

  // result status codes
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_TAG_OK  = 2'd1;
  localparam logic [1:0] ST_TAG_BAD = 2'd2;
  localparam logic [1:0] ST_BAD_LEN = 2'd3;

endpackage

>>> sim/ccm_checker.sv
`timescale 1ns / 100ps
module ccm_checker
  import aesccm_pkg::*;
  import ccm_tb_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  wire          full,
  input  in_item_t     in_item,
  input  wire          empty,
  input  wire          pop,
  input  out_item_t    out_item,
  input  wire          wr_en,
  input  wire  [2:0]   wr_index,
  input  wire  [63:0]  wr_data,
  output int           pending,
  output int           errors,
  output logic [127:0] tag_now
);

  localparam logic [2047:0] SUB_TABLE = {
    256'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0,
    256'hb7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b275,
    256'h09832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf,
    256'hd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2,
    256'hcd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdb,
    256'he0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08,
    256'hba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9e,
    256'he1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16
  };

  // configuration copy
  logic [63:0]  key_h, key_l, nonce_l, alen, plen;
  logic [39:0]  nonce_h;
  logic [3:0]   nbytes;
  logic [4:0]   tbytes;

  // ccm state
  logic [127:0] rkeys [11];
  logic [127:0] mac, s0, abuf;
  logic [63:0]  ctr, aseen, pseen;
  int           afill;

  out_item_t    expected_results [$];

  function automatic logic [7:0] sub(input logic [7:0] x);
    return SUB_TABLE[(255 - int'(x)) * 8 +: 8];
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] v, input int j);
    return v[127 - 8 * j -: 8];
  endfunction

  // full aes-128 encryption with the current schedule
  function automatic logic [127:0] cipher(input logic [127:0] x);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] v;
    v = x ^ rkeys[0];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = sub(byte_at(v, i));
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i + 4 * c] = s[i + 4 * ((c + i) & 3)];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        if (r < 10) begin
          v[127 - 32 * c -: 8] = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
          v[119 - 32 * c -: 8] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
          v[111 - 32 * c -: 8] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
          v[103 - 32 * c -: 8] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
        end else begin
          v[127 - 32 * c -: 32] = {a0, a1, a2, a3};
        end
      end
      v = v ^ rkeys[r];
    end
    return v;
  endfunction

  function automatic int nonce_len();
    return (nbytes < 7) ? 7 : ((nbytes > 13) ? 13 : int'(nbytes));
  endfunction

  // flags, nonce, then v big-endian in the counter field
  function automatic logic [127:0] ccm_block(input logic [7:0] flags, input logic [63:0] v);
    logic [127:0] b;
    int n;
    n = nonce_len();
    b = '0;
    b[127 -: 8] = flags;
    for (int k = 0; k < n; k++)
      b[119 - 8 * k -: 8] = (k < 5) ? nonce_h[39 - 8 * k -: 8] : nonce_l[63 - 8 * (k - 5) -: 8];
    for (int k = 0; k < 15 - n; k++) b[8 * k +: 8] = v[8 * k +: 8];
    return b;
  endfunction

  task automatic expand_key();
    logic [127:0] p;
    logic [31:0] tw, w0, w1, w2, w3;
    logic [7:0] rc;
    rkeys[0] = {key_h, key_l};
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      p = rkeys[r - 1];
      tw = {sub(p[23:16]), sub(p[15:8]), sub(p[7:0]), sub(p[31:24])} ^ {rc, 24'h0};
      w0 = p[127:96] ^ tw;
      w1 = p[95:64] ^ w0;
      w2 = p[63:32] ^ w1;
      w3 = p[31:0] ^ w2;
      rkeys[r] = {w0, w1, w2, w3};
      rc = dbl(rc);
    end
  endtask

  task automatic absorb(input logic [127:0] b);
    mac = cipher(mac ^ b);
  endtask

  task automatic assoc_byte(input logic [7:0] v);
    abuf[127 - 8 * afill -: 8] = v;
    afill++;
    if (afill >= 16) begin
      absorb(abuf);
      abuf = '0;
      afill = 0;
    end
  endtask

  task automatic assoc_flush();
    if (afill > 0) begin
      absorb(abuf);
      abuf = '0;
      afill = 0;
    end
  endtask

  function automatic bit lengths_valid(input bit dec);
    int q;
    q = 15 - nonce_len();
    if (nbytes < 7 || nbytes > 13) return 0;
    if (tbytes < 4 || tbytes > 16 || tbytes[0]) return 0;
    if (q < 8 && (plen >> (8 * q)) != 0) return 0;
    if (aseen != alen || pseen != plen) return 0;
    if (dec && plen == 0) return 0;
    return 1;
  endfunction

  // predict one accepted item
  task automatic ccm_step(input in_item_t it);
    logic [127:0] din, ks, res, pt;
    logic [7:0] flags, d;
    out_item_t o;
    int q, t, cnt;
    bit same;
    q = 15 - nonce_len();
    t = (tbytes < 4) ? 4 : ((tbytes > 16) ? 16 : int'(tbytes));
    t = t & ~1;
    cnt = (it.byte_count > 16) ? 16 : int'(it.byte_count);
    din = {it.data_high, it.data_low};
    o = '0;
    case (it.cmd)
      CMD_START: begin
        flags = ((alen != 0) ? 8'h40 : 8'h00) | 8'(((t - 2) / 2) << 3) | 8'(q - 1);
        expand_key();
        mac = cipher(ccm_block(flags, plen));
        s0 = cipher(ccm_block(8'(q - 1), 64'd0));
        ctr = 1;
        abuf = '0;
        afill = 0;
        aseen = 0;
        pseen = 0;
        // length header: 2, 6 or 10 bytes
        if (alen != 0) begin
          if (alen < 64'd65280) begin
            assoc_byte(alen[15:8]);
            assoc_byte(alen[7:0]);
          end else if (alen < 64'h1_0000_0000) begin
            assoc_byte(8'hff);
            assoc_byte(8'hfe);
            for (int j = 0; j < 4; j++) assoc_byte(alen[31 - 8 * j -: 8]);
          end else begin
            assoc_byte(8'hff);
            assoc_byte(8'hff);
            for (int j = 0; j < 8; j++) assoc_byte(alen[63 - 8 * j -: 8]);
          end
        end
      end
      CMD_ASSOC: begin
        for (int j = 0; j < cnt; j++) assoc_byte(byte_at(din, j));
        aseen += cnt;
      end
      CMD_ENCRYPT, CMD_DECRYPT: begin
        if (cnt != 0) begin
          assoc_flush();
          ks = cipher(ccm_block(8'(q - 1), ctr));
          res = '0;
          pt = '0;
          for (int j = 0; j < cnt; j++) begin
            d = byte_at(din, j);
            res[127 - 8 * j -: 8] = d ^ byte_at(ks, j);
            pt[127 - 8 * j -: 8] = (it.cmd == CMD_ENCRYPT) ? d : (d ^ byte_at(ks, j));
          end
          absorb(pt);
          ctr++;
          pseen += cnt;
          o.result_high = res[127:64];
          o.result_low = res[63:0];
          o.result_bytes = 5'(cnt);
          o.status = ST_DATA;
          expected_results.push_back(o);
        end
      end
      CMD_FIN_ENC, CMD_FIN_DEC: begin
        assoc_flush();
        if (!lengths_valid(it.cmd == CMD_FIN_DEC)) begin
          o.status = ST_BAD_LEN;
        end else if (it.cmd == CMD_FIN_ENC) begin
          res = '0;
          for (int j = 0; j < t; j++) res[127 - 8 * j -: 8] = byte_at(mac ^ s0, j);
          o.result_high = res[127:64];
          o.result_low = res[63:0];
          o.result_bytes = 5'(t);
          o.status = ST_DATA;
        end else begin
          same = 1;
          for (int j = 0; j < t; j++)
            if ((byte_at(din, j) ^ byte_at(s0, j)) != byte_at(mac, j)) same = 0;
          o.status = same ? ST_TAG_OK : ST_TAG_BAD;
        end
        expected_results.push_back(o);
      end
      default: ;
    endcase
  endtask

  task automatic compare(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result item %h", got);
      errors++;
    end else begin
      want = expected_results.pop_front();
      if (got.result_high !== want.result_high) begin
        $error("result_high expected %h got %h", want.result_high, got.result_high);
        errors++;
      end
      if (got.result_low !== want.result_low) begin
        $error("result_low expected %h got %h", want.result_low, got.result_low);
        errors++;
      end
      if (got.result_bytes !== want.result_bytes) begin
        $error("result_bytes expected %0d got %0d", want.result_bytes, got.result_bytes);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status);
        errors++;
      end
    end
  endtask

  initial errors = 0;

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      key_h = '0; key_l = '0; nonce_h = '0; nonce_l = '0;
      nbytes = 4'd13; tbytes = 5'd16; alen = '0; plen = '0;
      for (int r = 0; r < 11; r++) rkeys[r] = '0;
      mac = '0; s0 = '0; abuf = '0; ctr = '0; aseen = '0; pseen = '0; afill = 0;
      expected_results.delete();
    end else begin
      if (pop && !empty) compare(out_item);
      if (wr_en) begin
        case (wr_index)
          REG_KEY_HIGH:    key_h = wr_data;
          REG_KEY_LOW:     key_l = wr_data;
          REG_NONCE_HIGH:  nonce_h = wr_data[39:0];
          REG_NONCE_LOW:   nonce_l = wr_data;
          REG_NONCE_BYTES: nbytes = wr_data[3:0];
          REG_TAG_BYTES:   tbytes = wr_data[4:0];
          REG_ASSOC_LEN:   alen = wr_data;
          REG_PAYLOAD_LEN: plen = wr_data;
          default: ;
        endcase
      end
      if (push && !full) ccm_step(in_item);
    end
    pending = expected_results.size();
    tag_now = mac ^ s0;
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import aesccm_pkg::*;
  import ccm_tb_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 100;

  logic         clk = 0;
  logic         rst = 1;
  logic         push = 0;
  logic         pop = 0;
  logic         wr_en = 0;
  logic [2:0]   wr_index = '0;
  logic [63:0]  wr_data = '0;
  in_item_t     in_item = '0;
  logic         full, empty;
  out_item_t    out_item;
  int           pending, errors;
  logic [127:0] tag_now;

  bit           calm = 0;
  int           sent = 0;
  int           quiet_cycles = 0;
  logic [63:0]  alen_cur, plen_cur;

  always #5 clk = ~clk;

  aes_ccm_engine uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  ccm_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .pending(pending), .errors(errors), .tag_now(tag_now)
  );

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 26);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || wr_en || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL aes_ccm_engine");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic [2:0] cmd, input logic [63:0] hi, input logic [63:0] lo,
                      input logic [4:0] cnt);
    while (!calm && $urandom_range(99) < 26) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    in_item <= '{cmd: cmd, data_high: hi, data_low: lo, byte_count: cnt};
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic settle();
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_cfg(input logic [63:0] kh, input logic [63:0] kl,
                           input logic [63:0] nh, input logic [63:0] nl,
                           input logic [63:0] nb, input logic [63:0] tb,
                           input logic [63:0] al, input logic [63:0] pl);
    logic [63:0] vals [8];
    vals = '{kh, kl, nh, nl, nb, tb, al, pl};
    for (int i = 0; i < 8; i++) begin
      wr_en <= 1;
      wr_index <= 3'(i);
      wr_data <= vals[i];
      @(posedge clk);
    end
    wr_en <= 0;
    @(posedge clk);
    alen_cur = al;
    plen_cur = pl;
  endtask

  // random lengths, mostly valid and small
  task automatic random_cfg();
    logic [63:0] nb, tb, al, pl;
    nb = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(7, 13);
    tb = ($urandom_range(9) == 0) ? $urandom_range(31) : 2 * $urandom_range(2, 8);
    case ($urandom_range(19))
      0: al = $urandom_range(65280, 70000);
      1: al = rnd64();
      2, 3, 4: al = 0;
      default: al = $urandom_range(1, 48);
    endcase
    case ($urandom_range(19))
      0: pl = rnd64();
      1: pl = 0;
      default: pl = $urandom_range(1, 64);
    endcase
    write_cfg(rnd64(), rnd64(), rnd64(), rnd64(), nb, tb, al, pl);
  endtask

  task automatic noise();
    send(3'($urandom_range(7)), rnd64(), rnd64(), 5'($urandom_range(31)));
  endtask

  // one ccm message under the current settings
  task automatic message(input bit dec, input bit noisy, input bit good_tag);
    int rem, c;
    logic [127:0] tag;
    send(CMD_START, rnd64(), rnd64(), 5'($urandom_range(31)));
    rem = (alen_cur > 200) ? $urandom_range(40) : int'(alen_cur);
    while (rem > 0) begin
      c = ($urandom_range(3) == 0) ? 16 : $urandom_range(1, 16);
      if (c > rem) c = rem;
      send(CMD_ASSOC, rnd64(), rnd64(), 5'(c));
      rem -= c;
      if (noisy && $urandom_range(9) == 0) noise();
    end
    rem = (plen_cur > 200) ? $urandom_range(40) : int'(plen_cur);
    while (rem > 0) begin
      c = ($urandom_range(3) == 0) ? 16 : $urandom_range(0, 16);
      if (c > rem) c = rem;
      send(dec ? CMD_DECRYPT : CMD_ENCRYPT, rnd64(), rnd64(), 5'(c));
      rem -= c;
      if (noisy && $urandom_range(9) == 0) noise();
    end
    if (dec) begin
      settle();
      tag = tag_now;
      if (!good_tag) tag[$urandom_range(127)] ^= 1'b1;
      send(CMD_FIN_DEC, tag[127:64], tag[63:0], 5'($urandom_range(31)));
    end else begin
      send(CMD_FIN_ENC, rnd64(), rnd64(), 5'($urandom_range(31)));
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: register extremes, both directions, bad tag, invalid lengths
    write_cfg('0, '0, '0, '0, 64'd13, 64'd16, 64'd0, 64'd16);
    message(0, 0, 1);
    write_cfg('1, '1, '1, '1, 64'd7, 64'd4, 64'd20, 64'd17);
    message(1, 0, 1);
    message(1, 0, 0);
    write_cfg('1, '1, '1, '1, 64'd15, 64'd31, '1, '1);
    message(0, 1, 1);
    write_cfg(rnd64(), rnd64(), rnd64(), rnd64(), 64'd0, 64'd0, 64'd3, 64'd0);
    message(1, 1, 1);

    // random messages, with one stretch of no idling
    for (int m = 0; sent < 650; m++) begin
      calm = (m >= 10 && m < 18);
      random_cfg();
      message($urandom_range(1), $urandom_range(4) == 0, $urandom_range(3) != 0);
    end
    calm = 0;

    settle();
    if (errors == 0) begin
      $display("PASS aes_ccm_engine");
    end else begin
      $display("FAIL aes_ccm_engine");
    end
    $finish;
  end

endmodule
